// File: design/tga_rle_packet_decoder_defines.svh
// Assertion macros for the TGA run-length packet decoder.
// Each macro is checked in simulation and compiles to nothing in synthesis.
// The using module provides clk_i and rst_ni.
`ifndef TGA_RLE_PACKET_DECODER_DEFINES_SVH
`define TGA_RLE_PACKET_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define TGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define TGA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define TGA_ASSERT(lbl, prop, msg)
`define TGA_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: design/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Shared widths, register indexes, depth codes and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_rle_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEPTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

  // Pixel depth codes
  localparam int unsigned DEPTH_W = 2;
  localparam logic [DEPTH_W-1:0] DEPTH_8  = 2'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_16 = 2'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_24 = 2'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_32 = 2'd3;

  // Register reset values
  localparam logic [DEPTH_W-1:0]    DEPTH_RST  = DEPTH_24;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 16'd1;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 16'd1;

  // Header byte fields
  localparam int unsigned HDR_REPEAT_BIT = 7;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // One classified pixel request
  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  count;
    logic        last;
  } pix_entry_t;

endpackage

`default_nettype wire

// File: design/tga_rle_byte_if.sv
// ----------------------------------------------------------------------------
// Byte stream channel
// Valid/ready channel that carries one compressed stream byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface tga_rle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: design/tga_rle_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel result channel
// Valid/ready channel that carries one decoded pixel with its run count.
// ----------------------------------------------------------------------------
`default_nettype none

interface tga_rle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  logic [7:0] chan3;
  logic [7:0] repeat_count;
  logic       image_last;

  modport source (
    output valid, output chan0, output chan1, output chan2, output chan3,
    output repeat_count, output image_last, input ready
  );
  modport sink (
    input valid, input chan0, input chan1, input chan2, input chan3,
    input repeat_count, input image_last, output ready
  );
endinterface

`default_nettype wire

// File: design/tga_rle_packet_decoder.sv
// ----------------------------------------------------------------------------
// TGA run-length packet decoder
// Decodes a TGA RLE byte stream into pixels with run counts and an
// end-of-image flag.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Payload
//  in_i     in   valid/ready    in_byte
//  out_o    out  valid/ready    chan0..chan3, repeat_count, image_last
//  cfg      in   cfg_we_i       cfg_index_i, cfg_data_i (no read-back)
//
//  One byte is taken every cycle while the request queue has room; the
//  front end's byte path sets this rate. A pixel is queued when its last
//  byte is taken and moves to the output register once that is free.
//  When the request queue fills, in_i.ready drops.
//  Reset clears decode state and loads depth 24-bit, image 1 x 1.
//  A depth, width or height write restarts decoding at a header byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tga_rle_packet_decoder_defines.svh"

module tga_rle_packet_decoder #(
  parameter int unsigned QUEUE_DEPTH = tga_rle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  tga_rle_byte_if.sink                       in_i,
  tga_rle_pix_if.source                      out_o,
  input  logic                               cfg_we_i,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tga_rle_pkg::*;

  logic               q_push, q_pop, q_full, q_empty;
  pix_entry_t         q_in, q_out;
  logic [DEPTH_W-1:0] depth_mode;

  tga_rle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .depth_mode_o (depth_mode),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (q_in)
  );

  tga_rle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .pop_entry_o  (q_out)
  );

  tga_rle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .depth_mode_i (depth_mode),
    .q_empty_i    (q_empty),
    .q_entry_i    (q_out),
    .q_pop_o      (q_pop),
    .out_o        (out_o)
  );

  // Checks
  `TGA_ASSERT_NEVER(a_push_full, q_push && q_full, "request pushed into full queue")
  `TGA_ASSERT(a_full_stall, q_full |-> !in_i.ready, "byte taken while queue is full")
  `TGA_ASSERT(a_pop_after_push, $rose(q_pop) |-> $past(q_push) || !$past(q_empty),
              "pop without a queued request")
  `TGA_ASSERT(a_count_nonzero, out_o.valid |-> (out_o.repeat_count != 8'd0),
              "result with zero repeat count")

endmodule

`default_nettype wire

// File: design/tga_rle_front.sv
// ----------------------------------------------------------------------------
// TGA RLE front end
// Holds the configuration, parses packet headers, gathers pixel bytes and
// counts pixels against the image size; pushes one request per raw pixel or run.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tga_rle_byte_if.sink                        in_i,
  input  logic                                cfg_we_i,
  input  logic [tga_rle_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic [tga_rle_pkg::DEPTH_W-1:0]     depth_mode_o,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output tga_rle_pkg::pix_entry_t             q_entry_o
);
  import tga_rle_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_REPEAT = 3'b010,
    PH_RAW    = 3'b100
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [7:0]            left_q, left_d;
  logic [1:0]            bip_q, bip_d;
  logic [2:0][7:0]       gather_q, gather_d;
  logic [31:0]           remain_q, remain_d;
  logic [31:0]           total_q, total_d;
  logic [DEPTH_W-1:0]    depth_q, depth_d;
  logic [CFG_DATA_W-1:0] width_q, width_d;
  logic [CFG_DATA_W-1:0] height_q, height_d;

  logic                  accept;
  logic                  pix_done;
  logic                  clip;
  logic [7:0]            count;
  logic                  last;
  logic [7:0]            left_after;
  logic [31:0]           pixel;
  logic [CFG_DATA_W-1:0] cfg_eff;

  assign in_i.ready   = !q_full_i;
  assign accept       = in_i.valid && !q_full_i;
  assign depth_mode_o = depth_q;

  // Zero width or height counts as one
  assign cfg_eff = (cfg_data_i == '0) ? CFG_DATA_W'(1) : cfg_data_i;

  // Place the current byte at its slot of the pixel word
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (2'(k) == bip_q) begin
        pixel[8*k +: 8] = in_i.in_byte;
      end else if (k < 3) begin
        pixel[8*k +: 8] = gather_q[k];
      end else begin
        pixel[8*k +: 8] = 8'd0;
      end
    end
  end

  // Clip a run to the pixels left in the image
  assign clip       = remain_q < {24'd0, left_q};
  assign count      = (phase_q == PH_REPEAT) ? (clip ? remain_q[7:0] : left_q) : 8'd1;
  assign last       = ({24'd0, count} == remain_q);
  assign left_after = (phase_q == PH_REPEAT || left_q == 8'd0) ? 8'd0 : left_q - 8'd1;
  assign pix_done   = (phase_q != PH_HEADER) && (bip_q == depth_q);

  assign q_push_o        = accept && pix_done;
  assign q_entry_o.pixel = pixel;
  assign q_entry_o.count = count;
  assign q_entry_o.last  = last;

  // Next state of configuration and decode state
  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    bip_d    = bip_q;
    gather_d = gather_q;
    remain_d = remain_q;
    depth_d  = depth_q;
    width_d  = width_q;
    height_d = height_q;
    total_d  = total_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDX_DEPTH:  depth_d  = cfg_data_i[DEPTH_W-1:0];
        CFG_IDX_WIDTH:  width_d  = cfg_eff;
        CFG_IDX_HEIGHT: height_d = cfg_eff;
        default: ;
      endcase
      total_d = 32'(width_d) * 32'(height_d);
      if (cfg_index_i == CFG_IDX_DEPTH || cfg_index_i == CFG_IDX_WIDTH ||
          cfg_index_i == CFG_IDX_HEIGHT) begin
        phase_d  = PH_HEADER;
        left_d   = 8'd0;
        bip_d    = 2'd0;
        remain_d = total_d;
      end
    end else if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          left_d  = {1'b0, in_i.in_byte[6:0]} + 8'd1;
          phase_d = in_i.in_byte[HDR_REPEAT_BIT] ? PH_REPEAT : PH_RAW;
          bip_d   = 2'd0;
        end
        PH_REPEAT, PH_RAW: begin
          gather_d = pixel[23:0];
          if (!pix_done) begin
            bip_d = bip_q + 2'd1;
          end else begin
            bip_d = 2'd0;
            if (last) begin
              phase_d  = PH_HEADER;
              left_d   = 8'd0;
              remain_d = total_q;
            end else begin
              left_d   = left_after;
              remain_d = remain_q - {24'd0, count};
              if (left_after == 8'd0) begin
                phase_d = PH_HEADER;
              end
            end
          end
        end
        default: phase_d = PH_HEADER;
      endcase
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      left_q   <= 8'd0;
      bip_q    <= 2'd0;
      remain_q <= 32'(WIDTH_RST) * 32'(HEIGHT_RST);
      total_q  <= 32'(WIDTH_RST) * 32'(HEIGHT_RST);
      depth_q  <= DEPTH_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      bip_q    <= bip_d;
      remain_q <= remain_d;
      total_q  <= total_d;
      depth_q  <= depth_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Gathered pixel bytes
  always_ff @(posedge clk_i) begin
    gather_q <= gather_d;
  end

endmodule

`default_nettype wire

// File: design/tga_rle_queue.sv
// ----------------------------------------------------------------------------
// TGA RLE request queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_queue #(
  parameter int unsigned DEPTH = tga_rle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  tga_rle_pkg::pix_entry_t push_entry_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output tga_rle_pkg::pix_entry_t pop_entry_o
);
  import tga_rle_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  pix_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o      = (cnt_q == CNT_MAX);
  assign empty_o     = (cnt_q == '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;
  assign pop_entry_o = mem_q[rd_ptr_q];

  // Store pushed requests
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/tga_rle_back.sv
// ----------------------------------------------------------------------------
// TGA RLE back end
// Expands a gathered pixel word into channels by depth and holds the
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [tga_rle_pkg::DEPTH_W-1:0] depth_mode_i,
  input  logic                            q_empty_i,
  input  tga_rle_pkg::pix_entry_t         q_entry_i,
  output logic                            q_pop_o,
  tga_rle_pix_if.source                   out_o
);
  import tga_rle_pkg::*;

  logic       valid_q;
  logic [7:0] c0_d, c1_d, c2_d, c3_d;
  logic [7:0] c0_q, c1_q, c2_q, c3_q;
  logic [7:0] count_q;
  logic       last_q;
  logic [31:0] g;

  assign g       = q_entry_i.pixel;
  assign q_pop_o = !q_empty_i && (!valid_q || out_o.ready);

  // Split the pixel word into channels
  always_comb begin
    c0_d = 8'd0;
    c1_d = 8'd0;
    c2_d = 8'd0;
    c3_d = 8'd0;
    case (depth_mode_i)
      DEPTH_8: begin
        c0_d = g[7:0];
      end
      DEPTH_16: begin
        c0_d = {g[4:0], 3'b000};
        c1_d = {g[9:5], 3'b000};
        c2_d = {g[14:10], 3'b000};
      end
      DEPTH_24: begin
        c0_d = g[7:0];
        c1_d = g[15:8];
        c2_d = g[23:16];
      end
      DEPTH_32: begin
        c0_d = g[7:0];
        c1_d = g[15:8];
        c2_d = g[23:16];
        c3_d = g[31:24];
      end
      default: ;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      c0_q    <= c0_d;
      c1_q    <= c1_d;
      c2_q    <= c2_d;
      c3_q    <= c3_d;
      count_q <= q_entry_i.count;
      last_q  <= q_entry_i.last;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.chan0        = c0_q;
  assign out_o.chan1        = c1_q;
  assign out_o.chan2        = c2_q;
  assign out_o.chan3        = c3_q;
  assign out_o.repeat_count = count_q;
  assign out_o.image_last   = last_q;

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TGA RLE packet decoder testbench
// Feeds compressed byte streams under random idling on both channels, walks a
// table of hand-picked cases first, and checks every decoded pixel against a
// cycle-free decoder model kept inside the bench, or the table's expected pixel.
// ----------------------------------------------------------------------------

module tb_top;
  import tga_rle_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned RANDOM_BYTES = 400;

  typedef enum logic [1:0] {
    AWAIT_HEADER = 2'd0,
    RUN_PIXEL    = 2'd1,
    RAW_PIXELS   = 2'd2
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic [7:0] repeat_count;
    logic       image_last;
  } pix_t;

  typedef struct packed {
    bit                    is_cfg;
    bit                    typed;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    pix_t                  want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tga_rle_byte_if byte_ch ();
  tga_rle_pix_if  pix_ch ();

  tga_rle_packet_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (byte_ch),
    .out_o       (pix_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Decoder model state and its copy of the registers
  logic [DEPTH_W-1:0]    cfg_depth;
  logic [CFG_DATA_W-1:0] cfg_width;
  logic [CFG_DATA_W-1:0] cfg_height;
  dec_phase_e            dec_ph;
  int unsigned           run_left;
  int unsigned           byte_pos;
  logic [31:0]           gather_word;
  int unsigned           pix_done;

  pix_t pending_pix[$];
  row_t dir_rows[$];

  bit          calm;
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned pixels_seen;
  int unsigned image_ends;
  int unsigned settings_run;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Pick an idle stretch: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void restart_decode();
    dec_ph      = AWAIT_HEADER;
    run_left    = 0;
    byte_pos    = 0;
    gather_word = '0;
    pix_done    = 0;
  endfunction

  // Advance the decoder model by one stream byte
  task automatic decode_byte(input logic [7:0] b, output bit got, output pix_t px);
    int unsigned bpp;
    int unsigned total;
    int unsigned remain;
    int unsigned cnt;
    got = 1'b0;
    px  = '0;
    bpp = int'(cfg_depth) + 1;
    total = ((cfg_width == 0) ? 1 : int'(cfg_width)) *
            ((cfg_height == 0) ? 1 : int'(cfg_height));
    if (dec_ph == AWAIT_HEADER) begin
      run_left    = int'(b[6:0]) + 1;
      dec_ph      = b[HDR_REPEAT_BIT] ? RUN_PIXEL : RAW_PIXELS;
      byte_pos    = 0;
      gather_word = '0;
      return;
    end
    gather_word = gather_word | (32'(b) << (8 * byte_pos));
    if (byte_pos + 1 < bpp) begin
      byte_pos++;
      return;
    end
    byte_pos = 0;
    remain = (pix_done < total) ? total - pix_done : 1;
    if (dec_ph == RUN_PIXEL) begin
      cnt = (run_left < remain) ? run_left : remain;
      run_left = 0;
    end else begin
      cnt = 1;
      run_left = (run_left > 0) ? run_left - 1 : 0;
    end
    // Unpack channels by pixel format
    case (cfg_depth)
      DEPTH_8: begin
        px.chan0 = gather_word[7:0];
      end
      DEPTH_16: begin
        px.chan0 = {gather_word[4:0], 3'b000};
        px.chan1 = {gather_word[9:5], 3'b000};
        px.chan2 = {gather_word[14:10], 3'b000};
      end
      DEPTH_24: begin
        px.chan0 = gather_word[7:0];
        px.chan1 = gather_word[15:8];
        px.chan2 = gather_word[23:16];
      end
      default: begin
        px.chan0 = gather_word[7:0];
        px.chan1 = gather_word[15:8];
        px.chan2 = gather_word[23:16];
        px.chan3 = gather_word[31:24];
      end
    endcase
    px.repeat_count = cnt[7:0];
    px.image_last   = (cnt == remain);
    got = 1'b1;
    gather_word = '0;
    if (px.image_last) begin
      restart_decode();
    end else begin
      pix_done += cnt;
      if (run_left == 0) dec_ph = AWAIT_HEADER;
    end
  endtask

  // Drop valid and hold until the decoder has nothing left in flight
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IDX_DEPTH: begin
        cfg_depth = data[DEPTH_W-1:0];
        restart_decode();
      end
      CFG_IDX_WIDTH: begin
        cfg_width = data;
        restart_decode();
      end
      CFG_IDX_HEIGHT: begin
        cfg_height = data;
        restart_decode();
      end
      default: ;
    endcase
  endtask

  // Send one byte request; on acceptance record what it should decode to
  task automatic send_byte(input logic [7:0] b, input bit typed, input pix_t want);
    int unsigned gap;
    bit got;
    pix_t px;
    gap = idle_len();
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    bytes_sent++;
    decode_byte(b, got, px);
    if (got) pending_pix.push_back(typed ? want : px);
  endtask

  function automatic void row_byte(input logic [7:0] b);
    row_t r = '0;
    r.data = {8'h00, b};
    dir_rows.push_back(r);
  endfunction

  function automatic void row_pix(input logic [7:0] b, input pix_t want);
    row_t r = '0;
    r.data  = {8'h00, b};
    r.typed = 1'b1;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    row_t r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    dir_rows.push_back(r);
  endfunction

  function automatic int unsigned pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 1;
    return $urandom_range(1, 6);
  endfunction

  function automatic logic [7:0] pick_header();
    logic [7:0] hdr;
    hdr[HDR_REPEAT_BIT] = 1'($urandom_range(0, 1));
    hdr[6:0] = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(8, 127))
                                           : 7'($urandom_range(0, 7));
    return hdr;
  endfunction

  task automatic check_chan(input string fld, input logic [7:0] e, input logic [7:0] a);
    if (a !== e) begin
      $error("%s: expected %0h, got %0h", fld, e, a);
      mismatches++;
    end
  endtask

  // Output side: random stalls on ready
  initial pix_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      pix_ch.ready <= 1'b0;
    end else begin
      pix_ch.ready <= 1'b1;
      stall_left = idle_len();
    end
  end

  // Compare each accepted pixel with the oldest pending one
  always @(posedge clk_i) begin
    pix_t e;
    if (rst_ni && pix_ch.valid && pix_ch.ready) begin
      pixels_seen++;
      if (pix_ch.image_last === 1'b1) image_ends++;
      if (pending_pix.size() == 0) begin
        $error("pixel request with none pending");
        mismatches++;
      end else begin
        e = pending_pix.pop_front();
        check_chan("chan0", e.chan0, pix_ch.chan0);
        check_chan("chan1", e.chan1, pix_ch.chan1);
        check_chan("chan2", e.chan2, pix_ch.chan2);
        check_chan("chan3", e.chan3, pix_ch.chan3);
        check_chan("repeat_count", e.repeat_count, pix_ch.repeat_count);
        check_chan("image_last", {7'd0, e.image_last}, {7'd0, pix_ch.image_last});
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int unsigned rand_bytes;
    int unsigned n;
    logic [7:0] b;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    calm            = 1'b0;
    mismatches      = 0;
    bytes_sent      = 0;
    pixels_seen     = 0;
    image_ends      = 0;
    settings_run    = 1;
    stall_left      = 0;
    quiet_cycles    = 0;
    rand_bytes      = 0;
    cfg_depth       = DEPTH_RST;
    cfg_width       = WIDTH_RST;
    cfg_height      = HEIGHT_RST;
    restart_decode();

    // Reset defaults (24-bit, 1 x 1): one raw pixel, then an oversized run cut to 1
    row_byte(8'h00);
    row_byte(8'hFF);
    row_byte(8'h00);
    row_pix(8'hAA, '{8'hFF, 8'h00, 8'hAA, 8'h00, 8'd1, 1'b1});
    row_byte(8'hFF);
    row_byte(8'h01);
    row_byte(8'h02);
    row_pix(8'h03, '{8'h01, 8'h02, 8'h03, 8'h00, 8'd1, 1'b1});
    // 16-bit with the top bit set, which must be dropped
    row_cfg(CFG_IDX_DEPTH, 16'(DEPTH_16));
    row_byte(8'h80);
    row_byte(8'hFF);
    row_pix(8'hFF, '{8'hF8, 8'hF8, 8'hF8, 8'h00, 8'd1, 1'b1});
    // Zero width counts as one; the unused index must change nothing
    row_cfg(CFG_IDX_WIDTH, 16'h0000);
    row_cfg(CFG_IDX_HEIGHT, 16'd3);
    row_cfg(CFG_IDX_DEPTH, 16'(DEPTH_8));
    row_cfg(CFG_IDX_UNUSED, 16'hFFFF);
    row_byte(8'h02);
    row_pix(8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b0});
    row_pix(8'h80, '{8'h80, 8'h00, 8'h00, 8'h00, 8'd1, 1'b0});
    row_pix(8'hFF, '{8'hFF, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1});
    // Run of 6 on a 3-pixel image is cut to 3
    row_byte(8'h85);
    row_pix(8'h5A, '{8'h5A, 8'h00, 8'h00, 8'h00, 8'd3, 1'b1});
    // 32-bit on the largest image
    row_cfg(CFG_IDX_DEPTH, 16'(DEPTH_32));
    row_cfg(CFG_IDX_WIDTH, 16'hFFFF);
    row_cfg(CFG_IDX_HEIGHT, 16'hFFFF);
    row_byte(8'h81);
    row_byte(8'h11);
    row_byte(8'h22);
    row_byte(8'h33);
    row_pix(8'h44, '{8'h11, 8'h22, 8'h33, 8'h44, 8'd2, 1'b0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        settings_run++;
      end else begin
        send_byte(dir_rows[i].data[7:0], dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random settings, each followed by a stream of packets
    while (rand_bytes < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      write_reg(CFG_IDX_DEPTH, 16'($urandom_range(0, 3)));
      write_reg(CFG_IDX_WIDTH, 16'(pick_dim()));
      write_reg(CFG_IDX_HEIGHT, 16'(pick_dim()));
      if ($urandom_range(0, 4) == 0) write_reg(CFG_IDX_UNUSED, 16'($urandom));
      settings_run++;
      n = $urandom_range(30, 90);
      repeat (n) begin
        b = (dec_ph == AWAIT_HEADER) ? pick_header() : 8'($urandom_range(0, 255));
        send_byte(b, 1'b0, '0);
        rand_bytes++;
      end
    end
    calm = 1'b0;

    // Drain
    byte_ch.valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Streamed %0d bytes under %0d register settings", bytes_sent, settings_run);
    $display("Checked %0d pixels, %0d of them closing an image", pixels_seen, image_ends);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: tga_rle_packet_decoder.f
+incdir+design
design/tga_rle_pkg.sv
design/tga_rle_byte_if.sv
design/tga_rle_pix_if.sv
design/tga_rle_front.sv
design/tga_rle_queue.sv
design/tga_rle_back.sv
design/tga_rle_packet_decoder.sv
test/tb_top.sv
